@@ rtl/gmob_pkg.sv @@
// shared constants and types for the gradient magnitude / orientation bin block
// no dependencies; used by every module under rtl/

package gmob_pkg;

  localparam int GRAD_BITS_DEF = 11;
  localparam int MAG_BITS      = 11;
  localparam int BIN_BITS      = 3;
  localparam int OUT_DATA_BITS = ((MAG_BITS + BIN_BITS + 7) / 8) * 8;

  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  // orientation bins, 30 degrees each over atan(gy/gx) + 90
  typedef enum logic [BIN_BITS-1:0] {
    BIN_000_030 = 3'd0,
    BIN_030_060 = 3'd1,
    BIN_060_090 = 3'd2,
    BIN_090_120 = 3'd3,
    BIN_120_150 = 3'd4,
    BIN_150_180 = 3'd5
  } bin_t;

  // sign of the slope numerator once the denominator is made non-negative
  typedef struct packed {
    logic a_neg;
    logic a_zero;
  } slope_sign_t;

endpackage

@@ rtl/gradient_magnitude_orientation_bin.sv @@
// top level: per-pixel gradient magnitude and 6-way orientation bin
// depends on gmob_pkg, gmob_square, gmob_bin, gmob_isqrt
//
// usage
//   in_*  : one transaction per pixel, tdata = {grad_y, grad_x}, both signed
//   out_* : one transaction per pixel, tdata = {orient_bin, magnitude}
//   orientation channel n of the pixel carries magnitude when n == orient_bin
// pipeline: GRAD_BITS + 3 register stages, one for absolute values, one for the
//   squares, one for the sum and bin compares, then one stage per result bit of
//   the square root
// throughput: one pixel per clock while out_tready is high, with every stage holding its own valid bit
// reset (rst_n low, synchronous) empties the pipeline; no other state exists
// when the receiver stalls, results stay in the output register and bubbles
//   further up are filled, so input is refused only once every stage is full
// magnitudes above 2047 (only possible for GRAD_BITS > 11) saturate

module gradient_magnitude_orientation_bin #(
  parameter int GRAD_BITS = gmob_pkg::GRAD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // grad_x, grad_y, zero padding
  input  logic [((2*GRAD_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // magnitude, orient_bin, zero padding
  output logic [gmob_pkg::OUT_DATA_BITS-1:0]     out_tdata
);

  localparam int SQ_W  = 2 * GRAD_BITS;
  localparam int SAT_W = (GRAD_BITS > gmob_pkg::MAG_BITS) ? GRAD_BITS : gmob_pkg::MAG_BITS;

  logic                         sq_valid, sq_ready;
  logic [SQ_W-1:0]              a_sq, b_sq;
  gmob_pkg::slope_sign_t        sign;

  logic                         bn_valid, bn_ready;
  logic [SQ_W-1:0]              sum_sq;
  gmob_pkg::bin_t               bin;

  logic [GRAD_BITS-1:0]         root;
  logic [gmob_pkg::BIN_BITS-1:0] out_bin;
  logic [SAT_W-1:0]             root_w;
  logic [gmob_pkg::MAG_BITS-1:0] magnitude;

  gmob_square #(.GRAD_BITS(GRAD_BITS)) u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .grad_x    (in_tdata[GRAD_BITS-1:0]),
    .grad_y    (in_tdata[2*GRAD_BITS-1:GRAD_BITS]),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .a_sq      (a_sq),
    .b_sq      (b_sq),
    .sign      (sign)
  );

  gmob_bin #(.GRAD_BITS(GRAD_BITS)) u_bin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .a_sq      (a_sq),
    .b_sq      (b_sq),
    .sign      (sign),
    .out_valid (bn_valid),
    .out_ready (bn_ready),
    .sum_sq    (sum_sq),
    .bin       (bin)
  );

  gmob_isqrt #(
    .ROOT_BITS (GRAD_BITS),
    .TAG_BITS  (gmob_pkg::BIN_BITS)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bn_valid),
    .in_ready  (bn_ready),
    .radicand  (sum_sq),
    .in_tag    (bin),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .root      (root),
    .out_tag   (out_bin)
  );

  always_comb begin
    root_w = SAT_W'(root);
    if (root_w > SAT_W'(gmob_pkg::MAG_MAX)) begin
      magnitude = gmob_pkg::MAG_MAX;
    end else begin
      magnitude = root_w[gmob_pkg::MAG_BITS-1:0];
    end
    out_tdata = gmob_pkg::OUT_DATA_BITS'({out_bin, magnitude});
  end

endmodule

@@ rtl/gmob_square.sv @@
// two pipeline stages: absolute values and slope sign, then the two squares
// depends on gmob_pkg

module gmob_square #(
  parameter int GRAD_BITS = gmob_pkg::GRAD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [GRAD_BITS-1:0]      grad_x,
  input  logic [GRAD_BITS-1:0]      grad_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2*GRAD_BITS-1:0]    a_sq,
  output logic [2*GRAD_BITS-1:0]    b_sq,
  output gmob_pkg::slope_sign_t     sign
);

  logic                    va_r, vb_r;
  logic                    rdy_a, rdy_b;
  logic [GRAD_BITS-1:0]    ax_r, ay_r;
  gmob_pkg::slope_sign_t   sgn_a_r, sgn_b_r;
  logic [2*GRAD_BITS-1:0]  a_sq_r, b_sq_r;

  logic [GRAD_BITS-1:0]    abs_x, abs_y;
  logic                    gx_neg, gy_neg, gy_zero;
  gmob_pkg::slope_sign_t   sgn_nxt;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    gx_neg  = grad_x[GRAD_BITS-1];
    gy_neg  = grad_y[GRAD_BITS-1];
    gy_zero = (grad_y == '0);
    // most negative code maps to its magnitude as an unsigned value
    abs_x   = gx_neg ? (~grad_x + 1'b1) : grad_x;
    abs_y   = gy_neg ? (~grad_y + 1'b1) : grad_y;
    // flipping both signs when gx < 0 keeps the denominator non-negative
    sgn_nxt.a_zero = gy_zero;
    sgn_nxt.a_neg  = gx_neg ? (!gy_neg && !gy_zero) : gy_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      ax_r    <= abs_x;
      ay_r    <= abs_y;
      sgn_a_r <= sgn_nxt;
    end
    if (rdy_b && va_r) begin
      a_sq_r  <= ay_r * ay_r;
      b_sq_r  <= ax_r * ax_r;
      sgn_b_r <= sgn_a_r;
    end
  end

  assign out_valid = vb_r;
  assign a_sq      = a_sq_r;
  assign b_sq      = b_sq_r;
  assign sign      = sgn_b_r;

endmodule

@@ rtl/gmob_bin.sv @@
// one pipeline stage: sum of squares and the orientation bin from exact compares
// depends on gmob_pkg

module gmob_bin #(
  parameter int GRAD_BITS = gmob_pkg::GRAD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*GRAD_BITS-1:0]    a_sq,
  input  logic [2*GRAD_BITS-1:0]    b_sq,
  input  gmob_pkg::slope_sign_t     sign,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2*GRAD_BITS-1:0]    sum_sq,
  output gmob_pkg::bin_t            bin
);

  localparam int SQ_W = 2 * GRAD_BITS;
  localparam int CMP_W = SQ_W + 2;

  logic              v_r;
  logic [SQ_W-1:0]   sum_r;
  gmob_pkg::bin_t    bin_r;

  logic [CMP_W-1:0]  a2w, b2w, a3, b3;
  gmob_pkg::bin_t    bin_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    a2w = CMP_W'(a_sq);
    b2w = CMP_W'(b_sq);
    a3  = (a2w << 1) + a2w;
    b3  = (b2w << 1) + b2w;
    if (sign.a_neg && (a2w >= b3)) begin
      bin_nxt = gmob_pkg::BIN_000_030;
    end else if (sign.a_neg && (a3 >= b2w)) begin
      bin_nxt = gmob_pkg::BIN_030_060;
    end else if (sign.a_neg || sign.a_zero) begin
      bin_nxt = gmob_pkg::BIN_060_090;
    end else if (a3 <= b2w) begin
      bin_nxt = gmob_pkg::BIN_090_120;
    end else if (a2w <= b3) begin
      bin_nxt = gmob_pkg::BIN_120_150;
    end else begin
      bin_nxt = gmob_pkg::BIN_150_180;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // sum is at most 2**(SQ_W-1), so no carry out
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum_r <= a_sq + b_sq;
      bin_r <= bin_nxt;
    end
  end

  assign out_valid = v_r;
  assign sum_sq    = sum_r;
  assign bin       = bin_r;

endmodule

@@ rtl/gmob_isqrt.sv @@
// pipelined integer square root, one result bit per stage, with a side tag
// depends on gmob_pkg for the default width

module gmob_isqrt #(
  parameter int ROOT_BITS = gmob_pkg::GRAD_BITS_DEF,
  parameter int TAG_BITS  = gmob_pkg::BIN_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*ROOT_BITS-1:0]    radicand,
  input  logic [TAG_BITS-1:0]       in_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ROOT_BITS-1:0]      root,
  output logic [TAG_BITS-1:0]       out_tag
);

  localparam int RAD_W = 2 * ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 2;
  localparam int SH_W  = ROOT_BITS + 4;

  logic                 v_r    [ROOT_BITS];
  logic [REM_W-1:0]     rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r [ROOT_BITS];
  logic [RAD_W-1:0]     rad_r  [ROOT_BITS];
  logic [TAG_BITS-1:0]  tag_r  [ROOT_BITS];

  logic                 rdy    [ROOT_BITS+1];
  logic                 s_v    [ROOT_BITS];
  logic [REM_W-1:0]     s_rem  [ROOT_BITS];
  logic [ROOT_BITS-1:0] s_root [ROOT_BITS];
  logic [RAD_W-1:0]     s_rad  [ROOT_BITS];
  logic [TAG_BITS-1:0]  s_tag  [ROOT_BITS];

  logic [REM_W-1:0]     rem_nxt  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_nxt [ROOT_BITS];

  logic [SH_W-1:0]      rem_sh   [ROOT_BITS];
  logic [SH_W-1:0]      trial    [ROOT_BITS];

  // ready ripples back from the output register
  always_comb begin
    rdy[ROOT_BITS] = out_ready;
    for (int i = ROOT_BITS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    for (int i = 0; i < ROOT_BITS; i++) begin
      if (i == 0) begin
        s_v[i]    = in_valid;
        s_rem[i]  = '0;
        s_root[i] = '0;
        s_rad[i]  = radicand;
        s_tag[i]  = in_tag;
      end else begin
        s_v[i]    = v_r[i-1];
        s_rem[i]  = rem_r[i-1];
        s_root[i] = root_r[i-1];
        s_rad[i]  = rad_r[i-1];
        s_tag[i]  = tag_r[i-1];
      end
      // bring down the next two radicand bits and try (4*root + 1)
      rem_sh[i] = {s_rem[i], s_rad[i][RAD_W-1 -: 2]};
      trial[i]  = {2'b00, s_root[i], 2'b01};
      if (rem_sh[i] >= trial[i]) begin
        rem_nxt[i]  = REM_W'(rem_sh[i] - trial[i]);
        root_nxt[i] = {s_root[i][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = REM_W'(rem_sh[i]);
        root_nxt[i] = {s_root[i][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_BITS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < ROOT_BITS; i++) begin
        if (rdy[i]) v_r[i] <= s_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_BITS; i++) begin
      if (rdy[i] && s_v[i]) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= s_rad[i] << 2;
        tag_r[i]  <= s_tag[i];
      end
    end
  end

  assign out_valid = v_r[ROOT_BITS-1];
  assign root      = root_r[ROOT_BITS-1];
  assign out_tag   = tag_r[ROOT_BITS-1];

endmodule

@@ rtl/gmob_checker.sv @@
// port-level checks for the gradient magnitude / orientation bin block
// depends on gmob_pkg; bound to gradient_magnitude_orientation_bin below

module gmob_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [gmob_pkg::OUT_DATA_BITS-1:0]  out_tdata
);

  localparam int MB = gmob_pkg::MAG_BITS;
  localparam int BB = gmob_pkg::BIN_BITS;

  logic [MB-1:0] mag;
  logic [BB-1:0] obin;

  assign mag  = out_tdata[MB-1:0];
  assign obin = out_tdata[MB+BB-1:MB];

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> obin <= BB'(gmob_pkg::BIN_150_180))
    else $error("orientation bin out of range");

  // zero magnitude only for a zero gradient, which bins as flat
  a_zero_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mag == '0 |-> obin == BB'(gmob_pkg::BIN_060_090))
    else $error("zero gradient not in the flat bin");

  // with no result waiting at the output, input is always taken
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid && !out_tvalid ##1 !in_tvalid && !out_tvalid |-> in_tready)
    else $error("input refused while the pipeline drains");

endmodule

bind gradient_magnitude_orientation_bin gmob_checker u_gmob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
